### hdl/aes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 shared definitions
// Substitution tables, field arithmetic and the command type.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int unsigned NumRounds   = 14;
   localparam int unsigned NumKeyWords = 4 * (NumRounds + 1);
   localparam int unsigned KeyAddrBits = $clog2(NumKeyWords);
   localparam int unsigned RoundBits   = $clog2(NumRounds + 1);
   localparam int unsigned CsrAddrBits = 6;

   localparam logic [CsrAddrBits-1:0] ADDR_KEY0 = 6'h00;
   localparam logic [CsrAddrBits-1:0] ADDR_KEY1 = 6'h08;
   localparam logic [CsrAddrBits-1:0] ADDR_KEY2 = 6'h10;
   localparam logic [CsrAddrBits-1:0] ADDR_KEY3 = 6'h18;
   localparam logic [CsrAddrBits-1:0] ADDR_DIR  = 6'h20;

   localparam logic [7:0]  GfPoly    = 8'h1b;
   localparam logic [31:0] RconFirst = 32'h0100_0000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                   key_load;   // load the four 64-bit key words into rk words 0..7
      logic                   key_step;   // derive one schedule word
      logic [KeyAddrBits-1:0] key_addr;   // word index written by key_step
      logic                   blk_load;   // take block, do initial key addition
      logic                   blk_round;  // perform one round
      logic [RoundBits-1:0]   round;      // round index (encryption order)
      logic                   last_round;
      logic                   decrypt;
   } aes_cmd_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      return t[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? GfPoly : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // Column is {row0, row1, row2, row3} with row0 in the top byte.
   function automatic logic [31:0] mix_col(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
              a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
              a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
              xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
   endfunction

   // Inverse mix as a pre-step (multiply by {05,00,04,00}) followed by forward mix.
   function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3, u, v;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      u = xtime(xtime(a0 ^ a2));
      v = xtime(xtime(a1 ^ a3));
      return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
   endfunction

endpackage

### hdl/aes_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 controller
// Sequences key expansion, the round loop and the result handshake.
// ----------------------------------------------------------------------------
module aes_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 key_dirty,
   input  logic                 direction,
   output aes_pkg::aes_cmd_type cmd
);
   import aes_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_EXPAND, ST_ROUND} state_type;

   state_type              state_ff, state_in;
   logic                   sched_ok_ff, sched_ok_in;
   logic [KeyAddrBits-1:0] kaddr_ff, kaddr_in;
   logic [RoundBits-1:0]   step_ff, step_in;
   logic                   dec_ff, dec_in;
   logic                   ovalid_ff, ovalid_in;
   logic                   take, done;

   // A pending result holds off the next request unless it is taken in the
   // same cycle, so the result register is only overwritten after it has been taken.
   assign req_tready = (state_ff == ST_IDLE) && sched_ok_ff && !key_dirty
                       && (!ovalid_ff || rsp_tready);
   assign take = req_tvalid && req_tready;
   assign done = (state_ff == ST_ROUND) && (step_ff == RoundBits'(NumRounds));
   assign rsp_tvalid = ovalid_ff;

   always_comb begin
      state_in    = state_ff;
      sched_ok_in = sched_ok_ff && !key_dirty;
      kaddr_in    = kaddr_ff;
      step_in     = step_ff;
      dec_in      = dec_ff;
      ovalid_in   = ovalid_ff && !rsp_tready;
      cmd         = '0;
      cmd.decrypt = dec_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!sched_ok_ff || key_dirty) begin
               cmd.key_load = 1'b1;
               kaddr_in     = KeyAddrBits'(8);
               sched_ok_in  = 1'b0;
               state_in     = ST_EXPAND;
            end else if (take) begin
               cmd.blk_load = 1'b1;
               cmd.decrypt  = direction;
               cmd.round    = direction ? RoundBits'(NumRounds) : '0;
               dec_in       = direction;
               step_in      = RoundBits'(1);
               state_in     = ST_ROUND;
            end
         end
         ST_EXPAND: begin
            cmd.key_step = 1'b1;
            cmd.key_addr = kaddr_ff;
            kaddr_in     = kaddr_ff + 1'b1;
            if (key_dirty) begin
               // Another key word changed mid-expansion; start over from the new key.
               state_in = ST_IDLE;
            end else if (kaddr_ff == KeyAddrBits'(NumKeyWords - 1)) begin
               sched_ok_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_ROUND: begin
            cmd.blk_round  = 1'b1;
            cmd.round      = dec_ff ? RoundBits'(NumRounds) - step_ff : step_ff;
            cmd.last_round = done;
            step_in        = step_ff + 1'b1;
            if (done) begin
               ovalid_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         sched_ok_ff <= 1'b0;
         kaddr_ff    <= '0;
         step_ff     <= '0;
         dec_ff      <= 1'b0;
         ovalid_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sched_ok_ff <= sched_ok_in;
         kaddr_ff    <= kaddr_in;
         step_ff     <= step_in;
         dec_ff      <= dec_in;
         ovalid_ff   <= ovalid_in;
      end
   end

endmodule

### hdl/aes_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 datapath
// Round-key memory with schedule generator, state register and round logic.
// ----------------------------------------------------------------------------
module aes_datapath (
   input  logic                 clock,
   input  aes_pkg::aes_cmd_type cmd,
   input  logic [255:0]         key,
   input  logic [127:0]         blk_in,
   input  logic                 last_in,
   output logic [127:0]         result,
   output logic                 result_last
);
   import aes_pkg::*;

   // Round keys are kept as 15 rows of 128 bits in a memory; a sliding window
   // of the last eight words drives the schedule.
   logic [127:0]  rk_mem [NumRounds+1];
   logic [255:0]  win_ff, win_in;
   logic [31:0]   rcon_ff, rcon_in;
   logic [127:0]  rk_rd;
   logic [127:0]  state_ff, state_in;
   logic [127:0]  res_ff;
   logic          last_ff, lastp_ff;
   logic [31:0]   t, new_word;
   logic [RoundBits-1:0] rd_addr;
   logic [127:0]  sr, sb, mx, pre;

   // Next schedule word from the window: word i-8 is in the top, i-1 at bottom.
   always_comb begin
      t = win_ff[31:0];
      if (cmd.key_addr[2:0] == 3'd0) begin
         t = sub_word({t[23:0], t[31:24]}) ^ rcon_ff;
      end else if (cmd.key_addr[2:0] == 3'd4) begin
         t = sub_word(t);
      end
      new_word = win_ff[255:224] ^ t;
      win_in   = win_ff;
      rcon_in  = rcon_ff;
      if (cmd.key_load) begin
         win_in  = key;
         rcon_in = RconFirst;
      end else if (cmd.key_step) begin
         win_in = {win_ff[223:0], new_word};
         if (cmd.key_addr[2:0] == 3'd0) begin
            rcon_in = {rcon_ff[30:24], 1'b0, 24'h0} ^ (rcon_ff[31] ? {GfPoly, 24'h0} : 32'h0);
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      rcon_ff <= rcon_in;
      if (cmd.key_load) begin
         rk_mem[0] <= key[255:128];
         rk_mem[1] <= key[127:0];
      end else if (cmd.key_step && cmd.key_addr[1:0] == 2'd3) begin
         rk_mem[cmd.key_addr[KeyAddrBits-1:2]] <= {win_ff[95:0], new_word};
      end
   end

   // Key read is registered ahead of use: the next round's key is fetched now.
   always_comb begin
      rd_addr = cmd.round;
      if (cmd.blk_load) begin
         rd_addr = cmd.decrypt ? RoundBits'(NumRounds - 1) : RoundBits'(1);
      end else if (cmd.blk_round && !cmd.last_round) begin
         rd_addr = cmd.decrypt ? cmd.round - 1'b1 : cmd.round + 1'b1;
      end
   end

   logic [127:0] rk_first;
   always_comb begin
      rk_first = cmd.decrypt ? rk_mem[NumRounds] : rk_mem[0];
   end

   always_ff @(posedge clock) begin
      rk_rd <= rk_mem[rd_addr];
   end

   // Byte b of the block sits at bits 127-8b; column c is bytes 4c..4c+3.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (cmd.decrypt) begin
               sr[127-8*(4*((c+r)%4)+r) -: 8] = state_ff[127-8*(4*c+r) -: 8];
            end else begin
               sr[127-8*(4*c+r) -: 8] = state_ff[127-8*(4*((c+r)%4)+r) -: 8];
            end
         end
      end
      for (int i = 0; i < 16; i++) begin
         sb[127-8*i -: 8] = cmd.decrypt ? inv_sbox(sr[127-8*i -: 8]) : sbox(sr[127-8*i -: 8]);
      end
      for (int c = 0; c < 4; c++) begin
         pre[127-32*c -: 32] = cmd.decrypt ? sb[127-32*c -: 32] ^ rk_rd[127-32*c -: 32]
                                           : sb[127-32*c -: 32];
         mx[127-32*c -: 32] = cmd.decrypt ? inv_mix_col(pre[127-32*c -: 32])
                                          : mix_col(pre[127-32*c -: 32]);
      end
      state_in = state_ff;
      if (cmd.blk_load) begin
         state_in = blk_in ^ rk_first;
      end else if (cmd.blk_round) begin
         if (cmd.last_round) begin
            state_in = sb ^ rk_rd;
         end else if (cmd.decrypt) begin
            state_in = mx;
         end else begin
            state_in = mx ^ rk_rd;
         end
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      if (cmd.blk_load) lastp_ff <= last_in;
      if (cmd.blk_round && cmd.last_round) begin
         res_ff  <= state_in;
         last_ff <= lastp_ff;
      end
   end

   assign result      = res_ff;
   assign result_last = last_ff;

endmodule

### hdl/aes256_block_cipher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 ECB block cipher
// Encrypts or decrypts 128-bit blocks with a 256-bit key held in registers.
//
//   Channel  Direction  Contents
//   req_     in         128-bit block, tlast marks end of message
//   rsp_     out        128-bit result, tlast copied from request
//   csr_     in/out     four 64-bit key words and a direction bit
//
// Each request passes through the shared round unit: one step that takes the block
// and adds the first round key, then 14 rounds reading one key row each. The
// result is valid after the last round, when the next request can already be
// taken. After reset, and again after any key write, a key load plus 52 schedule
// words expand the key before a request is taken. A result that is not taken
// holds off the next request.
// ----------------------------------------------------------------------------
module aes256_block_cipher_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [127:0]                      req_tdata,  // block_high, block_low
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [127:0]                      rsp_tdata,  // result_high, result_low
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [aes_pkg::CsrAddrBits-1:0]   csr_paddr,
   input  logic [63:0]                       csr_pwdata,
   output logic [63:0]                       csr_prdata,
   output logic                              csr_pready
);
   import aes_pkg::*;

   logic [63:0]  key0_ff, key1_ff, key2_ff, key3_ff;
   logic         dir_ff, dirty_ff;
   logic         wr;
   aes_cmd_type  cmd;
   logic [127:0] res;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0; key1_ff <= '0; key2_ff <= '0; key3_ff <= '0;
         dir_ff <= 1'b0; dirty_ff <= 1'b0;
      end else begin
         dirty_ff <= 1'b0;
         if (wr) begin
            case (csr_paddr)
               ADDR_KEY0: begin key0_ff <= csr_pwdata; dirty_ff <= 1'b1; end
               ADDR_KEY1: begin key1_ff <= csr_pwdata; dirty_ff <= 1'b1; end
               ADDR_KEY2: begin key2_ff <= csr_pwdata; dirty_ff <= 1'b1; end
               ADDR_KEY3: begin key3_ff <= csr_pwdata; dirty_ff <= 1'b1; end
               ADDR_DIR:  dir_ff <= csr_pwdata[0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      case (csr_paddr)
         ADDR_KEY0: csr_prdata = key0_ff;
         ADDR_KEY1: csr_prdata = key1_ff;
         ADDR_KEY2: csr_prdata = key2_ff;
         ADDR_KEY3: csr_prdata = key3_ff;
         ADDR_DIR:  csr_prdata = {63'h0, dir_ff};
         default:   csr_prdata = '0;
      endcase
   end

   aes_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .key_dirty  (dirty_ff),
      .direction  (dir_ff),
      .cmd        (cmd)
   );

   aes_datapath u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .key         ({key0_ff, key1_ff, key2_ff, key3_ff}),
      .blk_in      ({req_tdata[63:0], req_tdata[127:64]}),
      .last_in     (req_tlast),
      .result      (res),
      .result_last (rsp_tlast)
   );

   assign rsp_tdata = {res[63:0], res[127:64]};

endmodule

### hdl/aes_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-256 port checker
// Watches the top-level ports for handshake and sequencing errors.
// ----------------------------------------------------------------------------
module aes_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [127:0] rsp_tdata
);

   // A held result keeps its data.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // No result appears in the cycle right after a request.
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result too early");

   // Two requests are never accepted back to back.
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted twice in a row");

   // A result stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before it was taken");

endmodule

bind aes256_block_cipher_top aes_checker u_aes_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata)
);
